// ===== design/gffc_pkg.sv =====
// shared types and constants of the greedy first-fit coloring block
package gffc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int ID_W         = 10;
  localparam int MAX_COLORS   = 64;
  localparam int COLOR_W      = 6;
  localparam int CNT_W        = 7;
  localparam int EPOCH_W      = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // input word
  typedef struct packed {
    logic            start_graph;
    logic [ID_W-1:0] vertex_id;
    logic [ID_W-1:0] neighbor_id;
    logic            neighbor_valid;
    logic            last_neighbor;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [ID_W-1:0]    colored_vertex;
    logic [COLOR_W-1:0] assigned_color;
    logic [CNT_W-1:0]   colors_used;
    logic               color_overflow;
  } out_word_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic            start;
    logic            last;
    logic            rd_en;
    logic            wr_en;
    logic [ID_W-1:0] vid;
    logic [ID_W-1:0] nid;
  } q_word_t;

  // one entry of the color store: epoch tag, colored flag, color
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic               colored;
    logic [COLOR_W-1:0] color;
  } entry_t;

endpackage

// ===== design/gffc_if.sv =====
// valid/ready channel interfaces for input and result words
interface gffc_in_if;
  logic               valid;
  logic               ready;
  gffc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gffc_out_if;
  logic                valid;
  logic                ready;
  gffc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/greedy_first_fit_vertex_coloring.sv =====
// top level of the greedy first-fit vertex coloring block
// Vertices arrive in coloring order, each as a run of neighbor words; the last word of a
// run returns one result with the lowest free color, and every word is accepted at one
// per cycle sustained unless a clearing pass runs or a waiting result is not taken.
// A four-entry queue sits in front of the color store lookup (one read, one write port),
// and a result register lets the next word enter while a result waits. With an empty
// queue a last word passes the queue, lookup and result registers before its result is
// valid. Stored colors carry a 4-bit graph epoch, so a start word costs nothing. A pass
// clearing all 1024 store entries (one per cycle) runs after reset and on epoch wrap: on
// the sixteenth start word after reset, then every fifteenth. Words wait while it runs.
module greedy_first_fit_vertex_coloring (
  input  logic       clk,
  input  logic       rst_n,
  gffc_in_if.sink    in_chan,
  gffc_out_if.source out_chan
);
  import gffc_pkg::*;

  logic    q_vld;
  q_word_t q_word;
  logic    q_pop;

  // accept and classify
  gffc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_vld   (q_vld),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  // lookup, assign and report
  gffc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== design/gffc_front.sv =====
// front end: accepts input words, classifies them and queues them for the back end
module gffc_front (
  input  logic              clk,
  input  logic              rst_n,
  gffc_in_if.sink           in_chan,
  output logic              q_vld,
  output gffc_pkg::q_word_t q_word,
  input  logic              q_pop
);
  import gffc_pkg::*;

  q_word_t             que_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head_r;
  logic [QPTR_W-1:0]   tail_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;
  logic                push;
  q_word_t             cls;

  // classify: does the word look up a neighbor, does it store a color
  always_comb begin
    cls.start = in_chan.data.start_graph;
    cls.last  = in_chan.data.last_neighbor;
    cls.rd_en = in_chan.data.neighbor_valid &&
                (32'(in_chan.data.neighbor_id) < MAX_VERTICES);
    cls.wr_en = 32'(in_chan.data.vertex_id) < MAX_VERTICES;
    cls.vid   = in_chan.data.vertex_id;
    cls.nid   = in_chan.data.neighbor_id;
  end

  assign in_chan.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_vld         = (cnt_r != '0);
  assign q_word        = que_r[head_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        tail_r <= tail_r + QPTR_W'(1);
      end
      if (q_pop) begin
        head_r <= head_r + QPTR_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      que_r[tail_r] <= cls;
    end
  end

endmodule

// ===== design/gffc_back.sv =====
// back end: color store lookup, taken mask, first-fit assignment and result register
module gffc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  gffc_pkg::q_word_t q_word,
  output logic              q_pop,
  gffc_out_if.source        out_chan
);
  import gffc_pkg::*;

  // color store with epoch tags
  entry_t                  mem [MAX_VERTICES];
  entry_t                  rd_data_r;

  logic [EPOCH_W-1:0]      epoch_r;
  logic                    clr_busy_r;
  logic [VTX_AW-1:0]       clr_cnt_r;

  logic                    b_vld_r;
  q_word_t                 b_word_r;
  logic                    b_fwd_hit_r;
  entry_t                  b_fwd_data_r;

  logic [MAX_COLORS-1:0]   mask_r;
  logic [MAX_COLORS-1:0]   mask_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;

  logic                    out_vld_r;
  out_word_t               out_data_r;

  logic                    head_wrap;
  logic                    out_free;
  logic                    b_fire;
  logic                    b_write;
  logic                    issue;
  logic                    clr_go;
  logic                    wr_en;
  logic [VTX_AW-1:0]       wr_addr;
  entry_t                  wr_data;
  entry_t                  new_entry;
  entry_t                  look;
  logic                    hit;
  logic [MAX_COLORS-1:0]   mask_base;
  logic [MAX_COLORS-1:0]   mask_cur;
  logic [CNT_W-1:0]        cnt_base;
  logic [MAX_COLORS-1:0]   open_mask;
  logic [MAX_COLORS-1:0]   free;
  logic [MAX_COLORS-1:0]   low;
  logic [COLOR_W-1:0]      idx;
  logic [COLOR_W-1:0]      color;
  logic                    ovf;

  // issue and stall control
  assign head_wrap = q_vld && q_word.start && (epoch_r == EPOCH_MAX);
  assign out_free  = !out_vld_r || out_chan.ready;
  assign b_fire    = b_vld_r && (!b_word_r.last || out_free);
  assign b_write   = b_fire && b_word_r.last && b_word_r.wr_en;
  assign issue     = q_vld && !clr_busy_r && !head_wrap && (!b_vld_r || b_fire);
  assign clr_go    = head_wrap && !clr_busy_r && !b_vld_r;
  assign q_pop     = issue;

  // store write port: clearing pass or color write
  assign wr_en   = clr_busy_r || b_write;
  assign wr_addr = clr_busy_r ? clr_cnt_r : b_word_r.vid[VTX_AW-1:0];
  assign wr_data = clr_busy_r ? entry_t'('0) : new_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[q_word.nid[VTX_AW-1:0]];
    end
  end

  // neighbor lookup with forwarding of a write made in the issue cycle
  always_comb begin
    look      = b_fwd_hit_r ? b_fwd_data_r : rd_data_r;
    hit       = b_word_r.rd_en && look.colored && (look.tag == epoch_r);
    mask_base = b_word_r.start ? '0 : mask_r;
    cnt_base  = b_word_r.start ? '0 : cnt_r;
    mask_cur  = mask_base;
    if (hit) begin
      mask_cur = mask_base | ({{(MAX_COLORS-1){1'b0}}, 1'b1} << look.color);
    end
  end

  // lowest free open color
  always_comb begin
    for (int i = 0; i < MAX_COLORS; i++) begin
      open_mask[i] = (CNT_W'(i) < cnt_base);
    end
    free = ~mask_cur & open_mask;
    low  = free & (~free + MAX_COLORS'(1));
    idx  = '0;
    for (int k = 0; k < COLOR_W; k++) begin
      for (int j = 0; j < MAX_COLORS; j++) begin
        if (((j >> k) & 1) == 1) begin
          idx[k] = idx[k] | low[j];
        end
      end
    end
  end

  // assignment, overflow and next state
  always_comb begin
    ovf      = 1'b0;
    color    = '0;
    cnt_nxt  = cnt_base;
    mask_nxt = mask_cur;
    if (b_word_r.last) begin
      mask_nxt = '0;
      if (free != '0) begin
        color = idx;
      end else if (cnt_base < CNT_W'(MAX_COLORS)) begin
        color   = cnt_base[COLOR_W-1:0];
        cnt_nxt = cnt_base + CNT_W'(1);
      end else begin
        ovf = 1'b1;
      end
    end
    new_entry.tag     = epoch_r;
    new_entry.colored = !ovf;
    new_entry.color   = color;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r    <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      b_vld_r    <= 1'b0;
      mask_r     <= '0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      // clearing pass after reset and on epoch wrap
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + VTX_AW'(1);
        if (clr_cnt_r == VTX_AW'(MAX_VERTICES - 1)) begin
          clr_busy_r <= 1'b0;
          epoch_r    <= '0;
        end
      end else if (clr_go) begin
        clr_busy_r <= 1'b1;
        clr_cnt_r  <= '0;
      end
      if (issue && q_word.start) begin
        epoch_r <= epoch_r + EPOCH_W'(1);
      end
      // lookup stage occupancy
      if (issue) begin
        b_vld_r <= 1'b1;
      end else if (b_fire) begin
        b_vld_r <= 1'b0;
      end
      if (b_fire) begin
        mask_r <= mask_nxt;
        cnt_r  <= cnt_nxt;
      end
      // result register
      if (b_fire && b_word_r.last) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      b_word_r     <= q_word;
      b_fwd_hit_r  <= b_write && (b_word_r.vid[VTX_AW-1:0] == q_word.nid[VTX_AW-1:0]);
      b_fwd_data_r <= new_entry;
    end
    if (b_fire && b_word_r.last) begin
      out_data_r.colored_vertex <= b_word_r.vid;
      out_data_r.assigned_color <= color;
      out_data_r.colors_used    <= cnt_nxt;
      out_data_r.color_overflow <= ovf;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_data_r;

  // the store has one write port: the clearing pass runs with the lookup stage empty
  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !b_vld_r && !q_pop)
    else $error("lookup stage active during clearing pass");

  // open color count never passes the palette size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_COLORS))
    else $error("open color count out of range");

  // overflow only once every color is open, and reports color zero
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.color_overflow |->
      out_data_r.colors_used == CNT_W'(MAX_COLORS) && out_data_r.assigned_color == '0)
    else $error("overflow with free palette");

  // an assigned color is always one of the open colors
  a_color_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.color_overflow |->
      CNT_W'(out_data_r.assigned_color) < out_data_r.colors_used)
    else $error("assigned color not open");

endmodule
